### sv/rgbaunp_pkg.sv
// Shared types and constants for the raw byte stream to RGBA unpacker.
// No dependencies; imported by every module of the block.
package rgbaunp_pkg;

	// Geometry limits, used as defaults for the top-level parameters
	localparam int DEF_MAX_PIXELS_PER_LINE = 4096;
	localparam int DEF_MAX_LINES           = 4096;
	// Larger pixel sizes are clamped to this many bytes
	localparam int MAX_PIXEL_BYTES         = 16;

	// Common compare width for geometry, holds any limit up to 65536
	localparam int GEO_W     = 17;
	// Byte-in-pixel counter width, holds data plus padding bytes
	localparam int BIP_W     = 9;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SKIP_BYTES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_SKIP_BYTES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_LINE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LITTLE_ENDIAN    = 3'd6;

	typedef enum logic [1:0] {
		PH_OFFSET,
		PH_PIXEL,
		PH_LINESKIP,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [4:0]  bytes_per_pixel;
		logic [7:0]  pixel_skip_bytes;
		logic [15:0] line_skip_bytes;
		logic [12:0] pixels_per_line;
		logic [12:0] line_count;
		logic [31:0] start_offset;
		logic        little_endian;
	} cfg_t;

	// Framer result for one byte
	typedef struct packed {
		logic        emit;
		logic        last_col;
		logic        last_line;
		logic [11:0] column;
		logic [11:0] row;
		logic [31:0] assembly;
		logic [4:0]  bpp;
	} pix_t;

endpackage

### sv/rgbaunp_convert.sv
// Pixel format conversion: assembled pixel bytes to RGBA8888.
// Depends on rgbaunp_pkg.
module rgbaunp_convert import rgbaunp_pkg::*; (
	input  logic [31:0] assembly,
	input  logic [4:0]  bpp,
	input  logic        little_endian,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha
);

	logic [7:0] pb [4];

	// byte j of the pixel, with optional order reversal
	always_comb begin
		logic [1:0] idx;
		for (int j = 0; j < 4; j++) begin
			idx = little_endian ? 2'(bpp - 5'd1 - 5'(j)) : 2'(j);
			pb[j] = assembly[8*idx +: 8];
		end
	end

	always_comb begin
		red   = 8'd0;
		green = 8'd0;
		blue  = 8'd0;
		alpha = 8'd255;
		unique case (bpp)
			5'd1: begin
				red   = pb[0];
				green = pb[0];
				blue  = pb[0];
			end
			5'd2: begin
				// RGB555, each channel scaled by 8
				red   = {pb[0][7:3], 3'b000};
				green = {pb[0][2:0], pb[1][7:6], 3'b000};
				blue  = {pb[1][5:1], 3'b000};
			end
			5'd3: begin
				red   = pb[0];
				green = pb[1];
				blue  = pb[2];
			end
			5'd4: begin
				red   = pb[0];
				green = pb[1];
				blue  = pb[2];
				alpha = pb[3];
			end
			default: begin
				// unsupported sizes: opaque black
				alpha = 8'd255;
			end
		endcase
	end

endmodule

### sv/rgbaunp_framer.sv
// Framing state: offset skip, pixel/line counters, padding and byte assembly.
// Depends on rgbaunp_pkg.
module rgbaunp_framer import rgbaunp_pkg::*; #(
	parameter int MAX_PIXELS_PER_LINE = DEF_MAX_PIXELS_PER_LINE,
	parameter int MAX_LINES           = DEF_MAX_LINES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] byte_value,
	input  logic       frame_start,
	input  cfg_t       cfg,
	output pix_t       pix
);

	localparam int COL_W = $clog2(MAX_PIXELS_PER_LINE + 1);
	localparam int LN_W  = $clog2(MAX_LINES + 1);
	localparam logic [GEO_W-1:0] PPL_MAX = GEO_W'(MAX_PIXELS_PER_LINE);
	localparam logic [GEO_W-1:0] NL_MAX  = GEO_W'(MAX_LINES);

	phase_t             phase_q, phase_n;
	logic [31:0]        off_q, off_n;
	logic [BIP_W-1:0]   bip_q, bip_n;
	logic [31:0]        asm_q, asm_n;
	logic [COL_W-1:0]   col_q, col_n;
	logic [LN_W-1:0]    line_q, line_n;
	logic [15:0]        ls_q, ls_n;

	always_comb begin
		phase_t           ph_c;
		logic [31:0]      off_c, asm_c, asm_upd;
		logic [BIP_W-1:0] bip_c, bip1, limit;
		logic [COL_W-1:0] col_c;
		logic [LN_W-1:0]  line_c;
		logic [15:0]      ls_c, ls1;
		logic [4:0]       bpp;
		logic [GEO_W-1:0] ppl, nl, ppl_raw, nl_raw;
		logic             go_pixel, end_line, last_col, last_line;

		// frame_start restarts everything before this byte is handled
		ph_c   = frame_start ? PH_OFFSET : phase_q;
		off_c  = frame_start ? 32'd0 : off_q;
		bip_c  = frame_start ? '0 : bip_q;
		asm_c  = frame_start ? 32'd0 : asm_q;
		col_c  = frame_start ? '0 : col_q;
		line_c = frame_start ? '0 : line_q;
		ls_c   = frame_start ? 16'd0 : ls_q;

		bpp = (cfg.bytes_per_pixel > 5'(MAX_PIXEL_BYTES)) ? 5'(MAX_PIXEL_BYTES)
			: cfg.bytes_per_pixel;

		ppl_raw = GEO_W'(cfg.pixels_per_line);
		nl_raw  = GEO_W'(cfg.line_count);
		ppl = (ppl_raw == '0) ? GEO_W'(1) : ((ppl_raw > PPL_MAX) ? PPL_MAX : ppl_raw);
		nl  = (nl_raw == '0) ? GEO_W'(1) : ((nl_raw > NL_MAX) ? NL_MAX : nl_raw);

		last_col  = (GEO_W'(col_c) + GEO_W'(1)) >= ppl;
		last_line = (GEO_W'(line_c) + GEO_W'(1)) >= nl;

		phase_n  = ph_c;
		off_n    = off_c;
		bip_n    = bip_c;
		asm_n    = asm_c;
		col_n    = col_c;
		line_n   = line_c;
		ls_n     = ls_c;
		go_pixel = 1'b0;
		end_line = 1'b0;
		ls1      = ls_c + 16'd1;
		bip1     = bip_c + BIP_W'(1);
		limit    = BIP_W'(bpp) + BIP_W'(cfg.pixel_skip_bytes);

		// byte lands in its lane while within the first four data bytes
		asm_upd = asm_c;
		if (bip_c < BIP_W'(4))
			asm_upd[8*bip_c[1:0] +: 8] = byte_value;

		if (bpp != 5'd0) begin
			unique case (ph_c)
				PH_OFFSET: begin
					if (off_c < cfg.start_offset) begin
						off_n = off_c + 32'd1;
					end else begin
						phase_n  = PH_PIXEL;
						go_pixel = 1'b1;
					end
				end
				PH_LINESKIP: begin
					ls_n = ls1;
					if (ls1 >= cfg.line_skip_bytes)
						end_line = 1'b1;
				end
				PH_PIXEL: go_pixel = 1'b1;
				PH_DONE:  go_pixel = 1'b0;
			endcase

			if (go_pixel) begin
				if (bip1 >= limit) begin
					bip_n = '0;
					asm_n = 32'd0;
					if (last_col) begin
						col_n = '0;
						if (last_line)
							phase_n = PH_DONE;
						else if (cfg.line_skip_bytes == 16'd0)
							end_line = 1'b1;
						else begin
							ls_n    = 16'd0;
							phase_n = PH_LINESKIP;
						end
					end else begin
						col_n = col_c + COL_W'(1);
					end
				end else begin
					bip_n = bip1;
					asm_n = asm_upd;
				end
			end

			if (end_line) begin
				ls_n    = 16'd0;
				line_n  = line_c + LN_W'(1);
				phase_n = last_line ? PH_DONE : PH_PIXEL;
			end
		end

		pix.emit      = go_pixel && (bip1 == BIP_W'(bpp));
		pix.last_col  = last_col;
		pix.last_line = last_line;
		pix.column    = 12'(GEO_W'(col_c));
		pix.row       = 12'(GEO_W'(line_c));
		pix.assembly  = asm_upd;
		pix.bpp       = bpp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OFFSET;
			off_q   <= 32'd0;
			bip_q   <= '0;
			asm_q   <= 32'd0;
			col_q   <= '0;
			line_q  <= '0;
			ls_q    <= 16'd0;
		end else if (advance) begin
			phase_q <= phase_n;
			off_q   <= off_n;
			bip_q   <= bip_n;
			asm_q   <= asm_n;
			col_q   <= col_n;
			line_q  <= line_n;
			ls_q    <= ls_n;
		end
	end

endmodule

### sv/raw_byte_stream_to_rgba_unpacker_core.sv
// Raw byte stream to RGBA8888 unpacker, top level.
// A byte is registered in stage 1, then its pixel in the output register that drives out_valid.
// Throughput: one byte per cycle while out_ready stays high; a held pixel stalls in_ready.
// Reset (arst_n low, async): registers to defaults, framing to offset skip, both
// pipeline registers empty. Depends on rgbaunp_pkg, rgbaunp_framer, rgbaunp_convert.
module raw_byte_stream_to_rgba_unpacker_core import rgbaunp_pkg::*; #(
	parameter int MAX_PIXELS_PER_LINE = DEF_MAX_PIXELS_PER_LINE,
	parameter int MAX_LINES           = DEF_MAX_LINES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	// byte input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           byte_value,
	input  logic                 frame_start,
	// pixel output channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue,
	output logic [7:0]           alpha,
	output logic [11:0]          column,
	output logic [11:0]          row,
	output logic                 end_of_line,
	output logic                 end_of_frame
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       advance;
	logic       out_valid_q;
	pix_t       pix;
	logic [7:0] r_c, g_c, b_c, a_c;

	// Configuration registers; writes must only arrive while the pipe is idle, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bytes_per_pixel  <= 5'd1;
			cfg_q.pixel_skip_bytes <= 8'd0;
			cfg_q.line_skip_bytes  <= 16'd0;
			cfg_q.pixels_per_line  <= 13'd1;
			cfg_q.line_count       <= 13'd1;
			cfg_q.start_offset     <= 32'd0;
			cfg_q.little_endian    <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BYTES_PER_PIXEL:  cfg_q.bytes_per_pixel  <= cfg_data[4:0];
				REG_PIXEL_SKIP_BYTES: cfg_q.pixel_skip_bytes <= cfg_data[7:0];
				REG_LINE_SKIP_BYTES:  cfg_q.line_skip_bytes  <= cfg_data[15:0];
				REG_PIXELS_PER_LINE:  cfg_q.pixels_per_line  <= cfg_data[12:0];
				REG_LINE_COUNT:       cfg_q.line_count       <= cfg_data[12:0];
				REG_START_OFFSET:     cfg_q.start_offset     <= cfg_data;
				REG_LITTLE_ENDIAN:    cfg_q.little_endian    <= cfg_data[0];
				default:              cfg_q                  <= cfg_q;
			endcase
		end
	end

	// Stage 1 holds one byte. It moves on (and the framing state steps) once
	// the output register is free or being drained this cycle; a byte that
	// yields no pixel still waits for that, keeping the control simple.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= byte_value;
			start_s1 <= frame_start;
		end
	end

	rgbaunp_framer #(
		.MAX_PIXELS_PER_LINE(MAX_PIXELS_PER_LINE),
		.MAX_LINES          (MAX_LINES)
	) u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.byte_value (byte_s1),
		.frame_start(start_s1),
		.cfg        (cfg_q),
		.pix        (pix)
	);

	rgbaunp_convert u_convert (
		.assembly     (pix.assembly),
		.bpp          (pix.bpp),
		.little_endian(cfg_q.little_endian),
		.red          (r_c),
		.green        (g_c),
		.blue         (b_c),
		.alpha        (a_c)
	);

	// Output register: loaded when stage 1 completes a pixel, holds under stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && pix.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pix.emit) begin
			red          <= r_c;
			green        <= g_c;
			blue         <= b_c;
			alpha        <= a_c;
			column       <= pix.column;
			row          <= pix.row;
			end_of_line  <= pix.last_col;
			end_of_frame <= pix.last_col && pix.last_line;
		end
	end

	assign out_valid = out_valid_q;

endmodule
